### sv/srl_pkg.sv
// ============================================================================
// srl_pkg: shared definitions for the stereo linear resampler
// Default widths, rate constants and the control word passed between the
// lane pipeline and the output stage.
// ============================================================================
`default_nettype none

package srl_pkg;

	localparam int FRAC_BITS_DEF   = 16;
	localparam int SAMPLE_BITS_DEF = 16;

	// Longest run of output words that one input frame can cause.
	localparam int MAX_RUN = 4;

	// Default step is the 44.1 kHz to 48 kHz ratio in fixed point.
	localparam longint unsigned STEP_NUM = 64'd44100;
	localparam longint unsigned STEP_DEN = 64'd48000;

	typedef struct packed {
		logic valid;
		logic last;
	} srl_ctl_t;

endpackage

`default_nettype wire

### sv/srl_lane.sv
// ============================================================================
// srl_lane: one channel of the interpolator
// Registers (cur - prev) * frac, then adds the floored, shifted product to
// the previous sample.
// ============================================================================
`default_nettype none

module srl_lane
	import srl_pkg::*;
#(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          en,
	input  wire logic signed [SAMPLE_BITS-1:0] prev,
	input  wire logic signed [SAMPLE_BITS-1:0] cur,
	input  wire logic        [FRAC_BITS-1:0]   frac,
	output logic signed      [SAMPLE_BITS-1:0] result
);

	localparam int PRODW = SAMPLE_BITS + FRAC_BITS + 2;

	logic signed [SAMPLE_BITS:0]   diff;
	logic signed [FRAC_BITS:0]     frac_s;
	logic signed [PRODW-1:0]       prod_s1;
	logic signed [SAMPLE_BITS-1:0] prev_s1;
	logic signed [SAMPLE_BITS+1:0] delta;
	logic        [SAMPLE_BITS+1:0] sum;

	assign diff   = {cur[SAMPLE_BITS-1], cur} - {prev[SAMPLE_BITS-1], prev};
	assign frac_s = signed'({1'b0, frac});

	always_ff @(posedge clk) begin
		if (en) begin
			prod_s1 <= diff * frac_s;
			prev_s1 <= prev;
		end
	end

	// Dropping the low fraction bits of a two's complement value floors it.
	assign delta  = signed'(prod_s1[PRODW-1:FRAC_BITS]);
	assign sum    = {{2{prev_s1[SAMPLE_BITS-1]}}, prev_s1} + delta;
	assign result = signed'(sum[SAMPLE_BITS-1:0]);

endmodule

`default_nettype wire

### sv/srl_merge.sv
// ============================================================================
// srl_merge: output stage
// Joins the two lane results and the run flag into the registered output
// word and produces the advance enable for the pipeline.
// ============================================================================
`default_nettype none

module srl_merge
	import srl_pkg::*;
#(
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire srl_ctl_t               ctl,
	input  wire logic [SAMPLE_BITS-1:0] left_res,
	input  wire logic [SAMPLE_BITS-1:0] right_res,
	output logic                        adv,
	output logic                        m_axis_tvalid,
	input  wire logic                   m_axis_tready,
	output logic [TDATA_W-1:0]          m_axis_tdata,
	output logic                        m_axis_tlast
);

	assign adv = !m_axis_tvalid || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tvalid <= 1'b0;
		end else if (adv) begin
			m_axis_tvalid <= ctl.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			m_axis_tdata <= TDATA_W'({right_res, left_res});
			m_axis_tlast <= ctl.last;
		end
	end

endmodule

`default_nettype wire

### sv/stereo_linear_resampler.sv
// ============================================================================
// stereo_linear_resampler: linear interpolation stereo upsampler
// Keeps the previous frame and a fractional phase and emits zero to four
// interpolated stereo words per input frame.
// ============================================================================
// Usage:
// The s_axis channel takes one stereo frame per word, left sample in the low
// half of tdata. The m_axis channel gives interpolated stereo words in the
// same layout, with tlast high on the final word caused by an input frame.
// The cfg channel writes phase_step (input rate over output rate, with
// FRAC_BITS fraction bits); cfg_ready is always high, and the step should
// only be changed while the block is idle.
// Timing: one frame is worked on at a time. After a frame is accepted the
// block issues one output word per cycle, unless the receiver stalls, into
// the two lane multipliers; s_axis_tready stays low until the last word issues.
// A word goes through the lane product registers and the output register to
// m_axis. A frame that arrives while the phase is already past one causes no
// word and is absorbed in its acceptance cycle.
// When the receiver stalls, the lane pipeline and the output register freeze
// together and no word is lost. Reset clears the phase, the previous frame
// and all valid flags, and loads the default 44.1 kHz to 48 kHz step.
// ============================================================================
`default_nettype none

module stereo_linear_resampler
	import srl_pkg::*;
#(
	parameter int FRAC_BITS   = FRAC_BITS_DEF,
	parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
	parameter int TDATA_W     = ((2 * SAMPLE_BITS + 7) / 8) * 8
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// Input frames.
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	input  wire logic [TDATA_W-1:0] s_axis_tdata,   // left_sample, right_sample
	// Output words.
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	output logic [TDATA_W-1:0]      m_axis_tdata,   // left_out, right_out
	output logic                    m_axis_tlast,   // last_of_run
	// Step register write channel.
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [FRAC_BITS:0] cfg_data        // phase_step
);

	// The running phase needs one bit more than the stored one, because a
	// step can carry it past two during the last addition of a run.
	localparam int PW = FRAC_BITS + 2;

	localparam logic [PW-1:0] PHASE_ONE = {2'b01, {FRAC_BITS{1'b0}}};
	localparam logic [FRAC_BITS:0] STEP_MIN = {3'b001, {(FRAC_BITS-2){1'b0}}};
	localparam longint unsigned STEP_RST_L = (STEP_NUM << FRAC_BITS) / STEP_DEN;
	localparam logic [FRAC_BITS:0] STEP_RST = STEP_RST_L[FRAC_BITS:0];
	localparam int CNT_W = $clog2(MAX_RUN);
	localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(MAX_RUN - 1);

	logic [FRAC_BITS:0]          step_q;
	logic [FRAC_BITS:0]          step_eff;
	logic [PW-1:0]               phase_q;
	logic [PW-1:0]               phase_sum;
	logic [PW-1:0]               phase_dec;
	logic [PW-1:0]               sum_dec;
	logic [PW-1:0]               phase_tail;
	logic                        phase_ge;
	logic                        sum_ge;
	logic                        busy_q;
	logic [CNT_W-1:0]            cnt_q;
	logic signed [SAMPLE_BITS-1:0] prev_l_q;
	logic signed [SAMPLE_BITS-1:0] prev_r_q;
	logic signed [SAMPLE_BITS-1:0] cur_l_q;
	logic signed [SAMPLE_BITS-1:0] cur_r_q;
	logic signed [SAMPLE_BITS-1:0] in_l;
	logic signed [SAMPLE_BITS-1:0] in_r;
	logic                        in_acc;
	logic                        adv;
	logic                        issue;
	logic                        is_last;
	logic                        v_s1;
	logic                        last_s1;
	srl_ctl_t                    ctl;
	logic [SAMPLE_BITS-1:0]      left_res;
	logic [SAMPLE_BITS-1:0]      right_res;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= STEP_RST;
		end else if (cfg_valid) begin
			step_q <= cfg_data;
		end
	end

	// A step below one quarter is raised to one quarter, capping a run at four.
	assign step_eff = (step_q < STEP_MIN) ? STEP_MIN : step_q;

	assign in_l = signed'(s_axis_tdata[SAMPLE_BITS-1:0]);
	assign in_r = signed'(s_axis_tdata[2*SAMPLE_BITS-1:SAMPLE_BITS]);

	assign s_axis_tready = !busy_q;
	assign in_acc        = s_axis_tvalid && !busy_q;
	assign issue         = busy_q && adv;

	assign phase_ge   = |phase_q[PW-1:FRAC_BITS];
	assign phase_dec  = phase_q - PHASE_ONE;
	assign phase_sum  = phase_q + {1'b0, step_eff};
	assign sum_ge     = |phase_sum[PW-1:FRAC_BITS];
	assign sum_dec    = phase_sum - PHASE_ONE;
	assign phase_tail = sum_ge ? sum_dec : phase_sum;
	assign is_last    = sum_ge || (cnt_q == CNT_LAST);

	// Run sequencer: one interpolation point is issued per advancing cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q   <= 1'b0;
			cnt_q    <= '0;
			phase_q  <= '0;
			prev_l_q <= '0;
			prev_r_q <= '0;
		end else if (in_acc) begin
			if (phase_ge) begin
				// Phase already past one: the frame only moves the window.
				phase_q  <= {1'b0, phase_dec[FRAC_BITS:0]};
				prev_l_q <= in_l;
				prev_r_q <= in_r;
			end else begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end
		end else if (issue) begin
			if (is_last) begin
				busy_q   <= 1'b0;
				phase_q  <= {1'b0, phase_tail[FRAC_BITS:0]};
				prev_l_q <= cur_l_q;
				prev_r_q <= cur_r_q;
			end else begin
				phase_q <= phase_sum;
				cnt_q   <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_acc) begin
			cur_l_q <= in_l;
			cur_r_q <= in_r;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			last_s1 <= 1'b0;
		end else if (adv) begin
			v_s1    <= issue;
			last_s1 <= is_last;
		end
	end

	assign ctl.valid = v_s1;
	assign ctl.last  = last_s1;

	srl_lane #(
		.FRAC_BITS  (FRAC_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_lane_l (
		.clk   (clk),
		.en    (adv),
		.prev  (prev_l_q),
		.cur   (cur_l_q),
		.frac  (phase_q[FRAC_BITS-1:0]),
		.result(left_res)
	);

	srl_lane #(
		.FRAC_BITS  (FRAC_BITS),
		.SAMPLE_BITS(SAMPLE_BITS)
	) u_lane_r (
		.clk   (clk),
		.en    (adv),
		.prev  (prev_r_q),
		.cur   (cur_r_q),
		.frac  (phase_q[FRAC_BITS-1:0]),
		.result(right_res)
	);

	srl_merge #(
		.SAMPLE_BITS(SAMPLE_BITS),
		.TDATA_W    (TDATA_W)
	) u_merge (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl          (ctl),
		.left_res     (left_res),
		.right_res    (right_res),
		.adv          (adv),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast)
	);

endmodule

`default_nettype wire

### sv/srl_checker.sv
// ============================================================================
// srl_checker: port-level checks for the stereo linear resampler
// Watches the top-level ports and is attached by the bind at the end.
// ============================================================================
`default_nettype none

module srl_checker #(
	parameter int TDATA_W = 32
) (
	input wire logic               clk,
	input wire logic               arst_n,
	input wire logic               s_axis_tvalid,
	input wire logic               s_axis_tready,
	input wire logic               m_axis_tvalid,
	input wire logic               m_axis_tready,
	input wire logic [TDATA_W-1:0] m_axis_tdata,
	input wire logic               m_axis_tlast,
	input wire logic               cfg_valid,
	input wire logic               cfg_ready
);

	// A stalled output word keeps its value and flag.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
		else $error("output word changed while stalled");

	// Nothing is offered on the output while reset is held.
	a_reset_idle: assert property (@(posedge clk)
		!arst_n |-> !m_axis_tvalid)
		else $error("output valid during reset");

	// Step writes are never refused.
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("step write refused");

	// No output word appears in the cycle right after an idle reset release.
	a_no_early_out: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("output word without any input");

	// The input only closes right after it has taken a frame.
	a_ready_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(s_axis_tready) |-> $past(s_axis_tvalid && s_axis_tready))
		else $error("input closed without an accepted frame");

endmodule

bind stereo_linear_resampler srl_checker #(
	.TDATA_W(TDATA_W)
) u_srl_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.s_axis_tvalid(s_axis_tvalid),
	.s_axis_tready(s_axis_tready),
	.m_axis_tvalid(m_axis_tvalid),
	.m_axis_tready(m_axis_tready),
	.m_axis_tdata (m_axis_tdata),
	.m_axis_tlast (m_axis_tlast),
	.cfg_valid    (cfg_valid),
	.cfg_ready    (cfg_ready)
);

`default_nettype wire

### sim/tb_stereo_linear_resampler.sv
// ============================================================================
// tb_stereo_linear_resampler: self-checking bench for the stereo resampler
// Drives stereo frames through the stream input, models the phase
// accumulator and interpolation in the bench, and checks every output word
// field by field. Covers the default step, the step extremes and random
// traffic under several patterns of sender gaps and receiver stalls.
// ============================================================================
`default_nettype none

module tb_stereo_linear_resampler;

	import srl_pkg::*;

	localparam int FRAC_W   = FRAC_BITS_DEF;
	localparam int SAMPLE_W = SAMPLE_BITS_DEF;
	localparam int TDATA_W  = ((2 * SAMPLE_W + 7) / 8) * 8;

	// One in fixed point, and the smallest step the block will use.
	localparam logic [FRAC_W+2:0] PHASE_ONE     = (FRAC_W+3)'(1) << FRAC_W;
	localparam logic [FRAC_W:0]   QUARTER_STEP  = (FRAC_W+1)'(1) << (FRAC_W - 2);
	localparam logic [FRAC_W:0]   UNITY_STEP    = (FRAC_W+1)'(1) << FRAC_W;
	localparam logic [FRAC_W:0]   MAX_STEP      = '1;
	localparam logic [FRAC_W:0]   DEFAULT_STEP  =
		(FRAC_W+1)'((STEP_NUM << FRAC_W) / STEP_DEN);

	// Cycles allowed after the last expected word before the block counts as idle.
	localparam int SETTLE_CYCLES = 8;

	typedef logic signed [SAMPLE_W-1:0] sample_t;

	typedef struct packed {
		sample_t left;
		sample_t right;
		logic    last;
	} stereo_word_t;

	logic               clk           = 1'b0;
	logic               arst_n;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata  = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	logic               m_axis_tlast;
	logic               cfg_valid     = 1'b0;
	logic               cfg_ready;
	logic [FRAC_W:0]    cfg_data      = '0;

	// Bench copy of the block state and its step register.
	logic [FRAC_W:0] step_shadow  = DEFAULT_STEP;
	logic [FRAC_W:0] phase_shadow = '0;
	sample_t         prev_left    = '0;
	sample_t         prev_right   = '0;

	// Interpolated words still owed by the block, oldest first.
	stereo_word_t pending_words[$];

	int mismatch_count = 0;
	int idle_pct       = 0;
	int stall_pct      = 0;

	stereo_linear_resampler #(
		.FRAC_BITS  (FRAC_W),
		.SAMPLE_BITS(SAMPLE_W)
	) DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tlast (m_axis_tlast),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_data     (cfg_data)
	);

	always #5 clk = ~clk;

	// The receiver stalls at random, at the rate the current phase asks for.
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	task automatic report_error(input string msg);
		$display("ERROR at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// prev + ((cur - prev) * frac) >> FRAC_W with a flooring shift. The result
	// always lies between the two samples, so truncation loses nothing.
	function automatic sample_t interpolate(input sample_t a, input sample_t b,
			input logic [FRAC_W-1:0] frac);
		longint diff;
		longint fr;
		fr   = longint'(frac);
		diff = (longint'(b) - longint'(a)) * fr;
		return sample_t'(longint'(a) + (diff >>> FRAC_W));
	endfunction

	// Works out the run of words that one accepted frame causes and advances
	// the bench copy of the phase and the previous frame.
	function automatic void predict_run(input sample_t cur_l, input sample_t cur_r);
		logic [FRAC_W+2:0] ph;
		logic [FRAC_W:0]   stp;
		stereo_word_t      run[MAX_RUN];
		int                n;
		stp = (step_shadow < QUARTER_STEP) ? QUARTER_STEP : step_shadow;
		ph  = {2'b00, phase_shadow};
		n   = 0;
		while (ph < PHASE_ONE && n < MAX_RUN) begin
			run[n].left  = interpolate(prev_left, cur_l, ph[FRAC_W-1:0]);
			run[n].right = interpolate(prev_right, cur_r, ph[FRAC_W-1:0]);
			run[n].last  = 1'b0;
			n++;
			ph += stp;
		end
		for (int i = 0; i < n; i++) begin
			run[i].last = (i == n - 1);
			pending_words.push_back(run[i]);
		end
		// A step above one can leave the phase past one; the next frame then
		// gives no word and only takes one off the phase.
		if (ph >= PHASE_ONE)
			ph -= PHASE_ONE;
		phase_shadow = ph[FRAC_W:0];
		prev_left    = cur_l;
		prev_right   = cur_r;
	endfunction

	// Output check: each accepted word against the oldest expected one.
	always @(posedge clk) begin
		stereo_word_t want;
		sample_t      got_l;
		sample_t      got_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got_l = m_axis_tdata[SAMPLE_W-1:0];
			got_r = m_axis_tdata[2*SAMPLE_W-1:SAMPLE_W];
			if (pending_words.size() == 0) begin
				report_error($sformatf("unexpected word L=%0d R=%0d last=%0b",
					got_l, got_r, m_axis_tlast));
			end else begin
				want = pending_words.pop_front();
				if (got_l !== want.left)
					report_error($sformatf("left_out %0d, expected %0d", got_l, want.left));
				if (got_r !== want.right)
					report_error($sformatf("right_out %0d, expected %0d", got_r, want.right));
				if (m_axis_tlast !== want.last)
					report_error($sformatf("last_of_run %0b, expected %0b",
						m_axis_tlast, want.last));
			end
		end
	end

	// Sends one frame, with a random gap in front of it, and predicts its run
	// once the block takes it. tvalid stays high afterwards so that the next
	// frame can follow without a bubble.
	task automatic send_frame(input sample_t l, input sample_t r);
		if ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			repeat ($urandom_range(6, 1)) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {r, l};
		do @(posedge clk); while (!s_axis_tready);
		predict_run(l, r);
	endtask

	// Stops sending and waits until every expected word has come out, plus a
	// few cycles for a frame that causes no word.
	task automatic wait_drained();
		s_axis_tvalid <= 1'b0;
		while (pending_words.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_step(input logic [FRAC_W:0] value);
		wait_drained();
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid   <= 1'b0;
		step_shadow  = value;
	endtask

	function automatic sample_t random_sample(input sample_t near);
		case ($urandom_range(3))
			0: return $urandom_range(1) ? sample_t'(16'h7FFF) : sample_t'(16'h8000);
			1: return sample_t'(near + sample_t'($urandom_range(64)) - sample_t'(32));
			default: return sample_t'($urandom);
		endcase
	endfunction

	function automatic logic [FRAC_W:0] random_step();
		case ($urandom_range(5))
			0: return QUARTER_STEP;
			1: return UNITY_STEP;
			2: return (FRAC_W+1)'($urandom_range(QUARTER_STEP - 1'b1));
			default: return (FRAC_W+1)'($urandom_range(UNITY_STEP, QUARTER_STEP));
		endcase
	endfunction

	// Default step after reset: the largest swings between the sample extremes.
	task automatic test_default_step();
		idle_pct  = 20;
		stall_pct = 20;
		send_frame(16'sh0000, 16'sh0000);
		send_frame(16'sh7FFF, -16'sh8000);
		send_frame(-16'sh8000, 16'sh7FFF);
		send_frame(16'sh7FFF, 16'sh7FFF);
		send_frame(-16'sh8000, -16'sh8000);
		send_frame(-16'sh0001, 16'sh0000);
		send_frame(16'sh0001, -16'sh0001);
		send_frame(16'sh1234, -16'sh4321);
	endtask

	// Quarter step gives the longest runs; a step below a quarter must act
	// exactly like a quarter.
	task automatic test_quarter_step();
		write_step(QUARTER_STEP);
		send_frame(16'sh7FFF, -16'sh8000);
		send_frame(-16'sh8000, 16'sh7FFF);
		send_frame(16'sh0000, 16'sh0001);
		write_step('0);
		send_frame(16'sh7FFF, -16'sh8000);
		send_frame(-16'sh8000, 16'sh7FFF);
		write_step(QUARTER_STEP - 1'b1);
		send_frame(16'sh0100, -16'sh0100);
	endtask

	task automatic test_unity_step();
		write_step(UNITY_STEP);
		send_frame(16'sh7FFF, -16'sh8000);
		send_frame(-16'sh8000, 16'sh7FFF);
	endtask

	// Steps above one leave the phase past one, so some frames give no word.
	task automatic test_step_above_one();
		write_step(MAX_STEP);
		send_frame(16'sh7FFF, -16'sh8000);
		send_frame(-16'sh8000, 16'sh7FFF);
		send_frame(16'sh2000, 16'sh0000);
		send_frame(-16'sh0001, 16'sh7FFF);
		write_step(UNITY_STEP + 1'b1);
		send_frame(16'sh7FFF, 16'sh7FFF);
		send_frame(-16'sh8000, -16'sh8000);
		send_frame(16'sh0000, 16'sh0000);
	endtask

	// Random frames at two step settings per idling pattern. The step write
	// between the halves makes the sender pause until all words are out.
	task automatic test_random_phase(input int sender_idle, input int receiver_stall,
			input logic [FRAC_W:0] first_step, input int frames);
		sample_t l;
		sample_t r;
		l         = '0;
		r         = '0;
		idle_pct  = sender_idle;
		stall_pct = receiver_stall;
		for (int half = 0; half < 2; half++) begin
			write_step(half == 0 ? first_step : random_step());
			repeat (frames / 2) begin
				l = random_sample(l);
				r = random_sample(r);
				send_frame(l, r);
			end
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_default_step();
		test_quarter_step();
		test_unity_step();
		test_step_above_one();

		test_random_phase(0, 0,
			(FRAC_W+1)'($urandom_range(UNITY_STEP, QUARTER_STEP)), 88);
		test_random_phase(71, 0, QUARTER_STEP, 88);
		test_random_phase(0, 71, UNITY_STEP, 88);
		test_random_phase(20, 20, (FRAC_W+1)'($urandom_range(MAX_STEP)), 88);

		wait_drained();
		if (mismatch_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

	// Far beyond the slowest correct run.
	initial begin
		#4000000;
		$display("Simulation FAILED");
		$finish;
	end

endmodule

`default_nettype wire
